@@ design/ckb_pkg.sv @@
// ckb_pkg: shared constants and types for the chroma key spill blend block.
// No dependencies.
package ckb_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned LumaN   = 4;

  localparam logic [PixW-1:0] KeyThrReset = 8'd51;
  localparam logic [3:0]      KeyGain     = 4'd6;
  localparam logic [10:0]     KeyLimit    = 11'd255;

  localparam logic [16:0] SpillUMul   = 17'd211;
  localparam logic [16:0] SpillVMul   = 17'd179;
  localparam logic [16:0] SpillOffset = 17'd4091;
  localparam logic [16:0] SpillU2Mul  = 17'd21;
  localparam logic [16:0] SpillV2Mul  = 17'd232;
  localparam logic [16:0] SpillLimit  = 17'd32498;
  localparam logic [PixW-1:0] SpillUv = 8'd128;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    logic key_on;
    logic spill;
  } key_t;

endpackage

@@ design/chroma_key_spill_blend.sv @@
// chroma_key_spill_blend: top level, input register, key logic, six blend units,
// result register. Depends on ckb_pkg, ckb_key, ckb_mix.
//
// Usage:
//  - Input: a transaction is taken at a rising edge with start_i high and busy_o
//    low. busy_o is always low, so one 2x2 block can be taken every clock.
//  - Output: the blended block is on out_* for exactly one cycle with done_o
//    high, after the input register and then the result register. The receiver
//    cannot stall; a result not taken in that cycle is gone.
//  - Throughput: one block per clock, set by the single combinational pass
//    (key compare, spill test, one blend add) between the two registers.
//  - Config: key_v_threshold_i is written at an edge with key_v_threshold_we_i
//    high; write only while no transaction is in flight.
//  - Reset: rst_ni low clears the valid flags and loads the threshold with 51;
//    no result strobe follows reset until a new transaction is taken.
module chroma_key_spill_blend import ckb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic key_v_threshold_we_i,
  input  pix_t key_v_threshold_i,
  input  pix_t fg_v_i,
  input  pix_t fg_u_i,
  input  pix_t bg_v_i,
  input  pix_t bg_u_i,
  input  pix_t fg_y_top_left_i,
  input  pix_t fg_y_top_right_i,
  input  pix_t fg_y_bottom_left_i,
  input  pix_t fg_y_bottom_right_i,
  input  pix_t bg_y_top_left_i,
  input  pix_t bg_y_top_right_i,
  input  pix_t bg_y_bottom_left_i,
  input  pix_t bg_y_bottom_right_i,
  output logic done_o,
  output pix_t out_v_o,
  output pix_t out_u_o,
  output pix_t out_y_top_left_o,
  output pix_t out_y_top_right_o,
  output pix_t out_y_bottom_left_o,
  output pix_t out_y_bottom_right_o
);

  pix_t thr_q;
  logic in_vld_q, out_vld_q;
  pix_t fg_v_q, fg_u_q, bg_v_q, bg_u_q;
  pix_t fg_y_q [LumaN];
  pix_t bg_y_q [LumaN];

  key_t key;
  pix_t fg_v_sel, fg_u_sel;
  pix_t v_d, u_d;
  pix_t y_d [LumaN];
  pix_t v_q, u_q;
  pix_t y_q [LumaN];

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= KeyThrReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (key_v_threshold_we_i) begin
        thr_q <= key_v_threshold_i;
      end
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fg_v_q     <= fg_v_i;
      fg_u_q     <= fg_u_i;
      bg_v_q     <= bg_v_i;
      bg_u_q     <= bg_u_i;
      fg_y_q[0]  <= fg_y_top_left_i;
      fg_y_q[1]  <= fg_y_top_right_i;
      fg_y_q[2]  <= fg_y_bottom_left_i;
      fg_y_q[3]  <= fg_y_bottom_right_i;
      bg_y_q[0]  <= bg_y_top_left_i;
      bg_y_q[1]  <= bg_y_top_right_i;
      bg_y_q[2]  <= bg_y_bottom_left_i;
      bg_y_q[3]  <= bg_y_bottom_right_i;
    end
  end

  ckb_key u_key (
    .fg_v_i (fg_v_q),
    .fg_u_i (fg_u_q),
    .thr_i  (thr_q),
    .key_o  (key)
  );

  assign fg_v_sel = key.spill ? SpillUv : fg_v_q;
  assign fg_u_sel = key.spill ? SpillUv : fg_u_q;

  ckb_mix u_mix_v (
    .fg_i     (fg_v_sel),
    .bg_i     (bg_v_q),
    .key_on_i (key.key_on),
    .mix_o    (v_d)
  );

  ckb_mix u_mix_u (
    .fg_i     (fg_u_sel),
    .bg_i     (bg_u_q),
    .key_on_i (key.key_on),
    .mix_o    (u_d)
  );

  for (genvar g = 0; g < LumaN; g++) begin : g_luma
    ckb_mix u_mix_y (
      .fg_i     (fg_y_q[g]),
      .bg_i     (bg_y_q[g]),
      .key_on_i (key.key_on),
      .mix_o    (y_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      v_q <= v_d;
      u_q <= u_d;
      for (int i = 0; i < LumaN; i++) begin
        y_q[i] <= y_d[i];
      end
    end
  end

  assign done_o               = out_vld_q;
  assign out_v_o              = v_q;
  assign out_u_o              = u_q;
  assign out_y_top_left_o     = y_q[0];
  assign out_y_top_right_o    = y_q[1];
  assign out_y_bottom_left_o  = y_q[2];
  assign out_y_bottom_right_o = y_q[3];

endmodule

@@ design/ckb_key.sv @@
// ckb_key: key decision from foreground V and green spill detection.
// Depends on ckb_pkg.
module ckb_key import ckb_pkg::*; (
  input  pix_t fg_v_i,
  input  pix_t fg_u_i,
  input  pix_t thr_i,
  output key_t key_o
);

  pix_t        diff;
  logic [10:0] scaled;
  logic [16:0] u_term;
  logic [16:0] v_term;
  logic [16:0] sum2;

  assign diff   = (fg_v_i > thr_i) ? (fg_v_i - thr_i) : '0;
  assign scaled = {3'b000, diff} * {7'd0, KeyGain};

  assign u_term = SpillUMul * {9'd0, fg_u_i};
  assign v_term = SpillOffset + SpillVMul * {9'd0, fg_v_i};
  assign sum2   = SpillU2Mul * {9'd0, fg_u_i} + SpillV2Mul * {9'd0, fg_v_i};

  assign key_o.key_on = scaled > KeyLimit;
  assign key_o.spill  = (u_term > v_term) && (sum2 < SpillLimit);

endmodule

@@ design/ckb_mix.sv @@
// ckb_mix: blends one foreground and one background byte with weight 255 or 0.
// Depends on ckb_pkg.
module ckb_mix import ckb_pkg::*; (
  input  pix_t fg_i,
  input  pix_t bg_i,
  input  logic key_on_i,
  output pix_t mix_o
);

  logic [15:0] acc;

  // 255*fg + bg = (fg << 8) - fg + bg
  assign acc   = {fg_i, 8'd0} - {8'd0, fg_i} + {8'd0, bg_i};
  assign mix_o = key_on_i ? acc[15:8] : bg_i;

endmodule
